// ----- design/tcc_pkg.sv -----
// Shared types, constants and helpers for the text console block.
// No dependencies; used by tcc_put_decode and text_console_cursor_scroll.
package tcc_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 11;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCROLL,
    S_FILL
  } state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [7:0]       char_code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } in_req_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [POS_W-1:0] cursor_pos;
    logic [7:0]       cell_glyph;
    logic [7:0]       cell_attr;
    logic             scrolled;
  } out_res_t;

  // Action of one put character request
  typedef struct packed {
    logic [COL_W-1:0] col;     // cursor after the request
    logic [ROW_W-1:0] row;
    logic             wr;      // write glyph at the old cursor
    logic             bs;      // blank glyph at the new cursor
    logic             scroll;  // scroll the screen up one row
  } put_act_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
                                                  logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
  endfunction

endpackage

// ----- design/tcc_put_decode.sv -----
// Cursor and store actions for one put character request.
// Depends on tcc_pkg.
module tcc_put_decode (
  input  logic [7:0]                tc_char,
  input  logic [tcc_pkg::COL_W-1:0] cur_col,
  input  logic [tcc_pkg::ROW_W-1:0] cur_row,
  output tcc_pkg::put_act_t         act
);

  localparam logic [tcc_pkg::COL_W-1:0] LAST_COL = tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1);
  localparam logic [tcc_pkg::ROW_W-1:0] BOTTOM   = tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1);

  logic [tcc_pkg::COL_W:0] tab_col;
  logic                    at_bottom;
  logic                    handled;

  assign tab_col   = {1'b0, cur_col} + (tcc_pkg::COL_W+1)'(4);
  assign at_bottom = (cur_row == BOTTOM);

  always_comb begin
    act     = '0;
    act.col = cur_col;
    act.row = cur_row;
    handled = 1'b0;
    if (tc_char == tcc_pkg::CH_NUL) begin
      handled = 1'b1;
    end else if ((tc_char == tcc_pkg::CH_LF || tc_char == tcc_pkg::CH_CR) && !at_bottom) begin
      act.row = cur_row + 1'b1;
      act.col = '0;
    end else if (tc_char == tcc_pkg::CH_TAB) begin
      if (tab_col >= (tcc_pkg::COL_W+1)'(tcc_pkg::COLUMNS)) begin
        act.col = tcc_pkg::COL_W'(tab_col - (tcc_pkg::COL_W+1)'(tcc_pkg::COLUMNS));
        if (at_bottom) begin
          act.scroll = 1'b1;   // wrapped column is kept
          handled    = 1'b1;
        end else begin
          act.row = cur_row + 1'b1;
        end
      end else begin
        act.col = tcc_pkg::COL_W'(tab_col);
      end
    end else if (tc_char == tcc_pkg::CH_BS) begin
      act.bs = 1'b1;
      if (cur_col == '0 && cur_row != '0) begin
        act.col = tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 2);
        act.row = cur_row - 1'b1;
      end else if (cur_col != '0) begin
        act.col = cur_col - 1'b1;
      end
    end else if (tc_char == tcc_pkg::CH_LF) begin
      act.scroll = 1'b1;
      act.col    = '0;
      handled    = 1'b1;
    end else if (cur_col == LAST_COL && !at_bottom) begin
      act.row = cur_row + 1'b1;
      act.col = '0;
    end else begin
      act.wr  = 1'b1;
      act.col = (cur_col == LAST_COL) ? '0 : cur_col + 1'b1;
      handled = 1'b1;
    end
    // landing on the bottom-right cell scrolls
    if (!handled && act.row == BOTTOM && act.col == LAST_COL) begin
      act.scroll = 1'b1;
      act.col    = '0;
    end
  end

endmodule

// ----- design/text_console_cursor_scroll.sv -----
// Text console top level: cell store, cursor, sweep sequencer, result buffering.
// Depends on tcc_pkg and tcc_put_decode.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one request per item, with
//    put character, clear screen, set cursor or read cell. Each request
//    gives exactly one result on the output channel (out_valid/out_stall/out_data).
//  - Config channel (cfg_valid/cfg_ready/cfg_data): the attribute byte used
//    for printed, cleared and scrolled-in cells. cfg_ready is always high.
//  - Set cursor, plain put character, non-scrolling control codes: done in the
//    accepting cycle; the result then passes the result and output registers.
//  - Read cell and backspace: the accepting cycle, then S_RDWAIT, since the cell
//    memory read is registered (backspace is a read-modify-write of one cell).
//  - Scroll: the accepting cycle, a copy of 1920 cells through the single read
//    port, then 80 blank writes. Clear screen: one cell written per cycle after
//    the accepting one.
//  - Reset: a clearing pass fills all 2000 cells with spaces in attribute 7;
//    no request is taken until it ends.
//  - A result register and a one-entry skid stage sit between the sides, so
//    a new request is taken while a finished result still waits. When the
//    receiver stalls, results hold and in_stall rises once both are full.
module text_console_cursor_scroll (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcc_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcc_pkg::out_res_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  localparam int AW = tcc_pkg::ADDR_W;
  localparam logic [AW-1:0] COPY_END = AW'(tcc_pkg::CELLS - tcc_pkg::COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(tcc_pkg::CELLS - 1);
  localparam logic [tcc_pkg::COL_W-1:0] LAST_COL = tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1);
  localparam logic [tcc_pkg::ROW_W-1:0] BOTTOM   = tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1);

  // Cell store: glyph in the low byte, attribute in the high byte
  logic [15:0] mem [tcc_pkg::CELLS];
  logic [15:0] rd_q_r;

  tcc_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               wr_addr_r, wr_addr_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]               tgt_addr_r, tgt_addr_nxt;
  logic                        is_bs_r, is_bs_nxt;
  logic                        item_r, item_nxt;
  logic                        scrolled_r, scrolled_nxt;
  logic [7:0]                  fill_attr_r, fill_attr_nxt;
  logic [7:0]                  attr_r;
  logic [tcc_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [tcc_pkg::ROW_W-1:0]   row_r, row_nxt;

  tcc_pkg::out_res_t res_r, res_nxt, out_r;
  logic              res_pend_r, out_valid_r;
  logic              res_move, done;
  logic [7:0]        done_glyph, done_attr;
  logic              done_scrolled;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic                      accept;
  logic [tcc_pkg::COL_W-1:0] clamp_col;
  logic [tcc_pkg::ROW_W-1:0] clamp_row;
  tcc_pkg::put_act_t         act;

  tcc_put_decode u_decode (
    .tc_char (in_data.char_code),
    .cur_col (col_r),
    .cur_row (row_r),
    .act     (act)
  );

  // Handshakes
  assign res_move  = res_pend_r && (!out_valid_r || !out_stall);
  assign in_stall  = !(state_r == tcc_pkg::S_IDLE && (!res_pend_r || res_move));
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign clamp_col = (in_data.col > LAST_COL) ? LAST_COL : in_data.col;
  assign clamp_row = (in_data.row > BOTTOM)   ? BOTTOM   : in_data.row;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcc_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            tcc_pkg::CMD_PUT: begin
              if (act.bs)          state_nxt = tcc_pkg::S_RDWAIT;
              else if (act.scroll) state_nxt = tcc_pkg::S_SCROLL;
            end
            tcc_pkg::CMD_CLEAR: state_nxt = tcc_pkg::S_FILL;
            tcc_pkg::CMD_READ:  state_nxt = tcc_pkg::S_RDWAIT;
            default:            state_nxt = tcc_pkg::S_IDLE;
          endcase
        end
      end
      tcc_pkg::S_RDWAIT: state_nxt = tcc_pkg::S_IDLE;
      tcc_pkg::S_SCROLL: begin
        if (cnt_r == COPY_END) state_nxt = tcc_pkg::S_FILL;
      end
      tcc_pkg::S_FILL: begin
        if (cnt_r == LAST_CELL) state_nxt = tcc_pkg::S_IDLE;
      end
      default: state_nxt = tcc_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_nxt       = cnt_r;
    wr_addr_nxt   = wr_addr_r;
    rd_pend_nxt   = 1'b0;
    tgt_addr_nxt  = tgt_addr_r;
    is_bs_nxt     = is_bs_r;
    item_nxt      = item_r;
    scrolled_nxt  = scrolled_r;
    fill_attr_nxt = fill_attr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = {fill_attr_r, tcc_pkg::CH_SP};
    mem_re        = 1'b0;
    mem_raddr     = cnt_r;
    done          = 1'b0;
    done_glyph    = '0;
    done_attr     = '0;
    done_scrolled = 1'b0;
    case (state_r)
      tcc_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            tcc_pkg::CMD_PUT: begin
              col_nxt = act.col;
              row_nxt = act.row;
              if (act.wr) begin
                mem_we    = 1'b1;
                mem_waddr = tcc_pkg::cell_addr(row_r, col_r);
                mem_wdata = {attr_r, in_data.char_code};
              end
              if (act.bs) begin
                mem_re       = 1'b1;
                mem_raddr    = tcc_pkg::cell_addr(act.row, act.col);
                tgt_addr_nxt = mem_raddr;
                is_bs_nxt    = 1'b1;
              end else if (act.scroll) begin
                cnt_nxt       = '0;
                item_nxt      = 1'b1;
                scrolled_nxt  = 1'b1;
                fill_attr_nxt = attr_r;
              end else begin
                done = 1'b1;
              end
            end
            tcc_pkg::CMD_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              cnt_nxt       = '0;
              item_nxt      = 1'b1;
              scrolled_nxt  = 1'b0;
              fill_attr_nxt = attr_r;
            end
            tcc_pkg::CMD_SET: begin
              col_nxt = clamp_col;
              row_nxt = clamp_row;
              done    = 1'b1;
            end
            tcc_pkg::CMD_READ: begin
              mem_re    = 1'b1;
              mem_raddr = tcc_pkg::cell_addr(clamp_row, clamp_col);
              is_bs_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      tcc_pkg::S_RDWAIT: begin
        done = 1'b1;
        if (is_bs_r) begin
          // keep attribute, blank the glyph
          mem_we    = 1'b1;
          mem_waddr = tgt_addr_r;
          mem_wdata = {rd_q_r[15:8], tcc_pkg::CH_SP};
        end else begin
          done_glyph = rd_q_r[7:0];
          done_attr  = rd_q_r[15:8];
        end
      end
      tcc_pkg::S_SCROLL: begin
        // read one row ahead, write the cell read last cycle
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = rd_q_r;
        end
        if (cnt_r != COPY_END) begin
          mem_re      = 1'b1;
          mem_raddr   = cnt_r + AW'(tcc_pkg::COLUMNS);
          rd_pend_nxt = 1'b1;
          wr_addr_nxt = cnt_r;
          cnt_nxt     = cnt_r + 1'b1;
        end
      end
      tcc_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = {fill_attr_r, tcc_pkg::CH_SP};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          item_nxt      = 1'b0;
          done          = item_r;
          done_scrolled = scrolled_r;
        end
      end
      default: ;
    endcase
  end

  // Result built from the cursor after the request
  always_comb begin
    res_nxt            = '0;
    res_nxt.cursor_col = col_nxt;
    res_nxt.cursor_row = row_nxt;
    res_nxt.cursor_pos = tcc_pkg::POS_W'(tcc_pkg::cell_addr(row_nxt, col_nxt));
    res_nxt.cell_glyph = done_glyph;
    res_nxt.cell_attr  = done_attr;
    res_nxt.scrolled   = done_scrolled;
  end

  // Cell memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    tgt_addr_r <= tgt_addr_nxt;
    is_bs_r    <= is_bs_nxt;
    if (done) begin
      res_r <= res_nxt;
    end
    if (res_move) begin
      out_r <= res_r;
    end
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcc_pkg::S_FILL;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      item_r      <= 1'b0;
      scrolled_r  <= 1'b0;
      fill_attr_r <= tcc_pkg::RESET_ATTR;
      attr_r      <= tcc_pkg::RESET_ATTR;
      col_r       <= '0;
      row_r       <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      item_r      <= item_nxt;
      scrolled_r  <= scrolled_nxt;
      fill_attr_r <= fill_attr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      if (done) begin
        res_pend_r <= 1'b1;
      end else if (res_move) begin
        res_pend_r <= 1'b0;
      end
      if (res_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- dv/tb_text_console_cursor_scroll.sv -----
// Testbench for text_console_cursor_scroll: directed and random console requests,
// checked against an in-bench model of the cell store and cursor.
// Depends on tcc_pkg and the text_console_cursor_scroll RTL.
`timescale 1ns / 100ps

import tcc_pkg::*;

// Console model plus the queue of results it expects, oldest first.
class console_scoreboard;
  logic [15:0]      cells [CELLS];   // {attribute, glyph}
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [7:0]       attr;
  out_res_t         expected_q [$];
  int               mismatches;
  int               checked;
  int               n_put, n_clear, n_set, n_read, n_scroll;

  function new();
    fill_blank(RESET_ATTR);
    cur_col = '0;
    cur_row = '0;
    attr = RESET_ATTR;
  endfunction

  function void fill_blank(logic [7:0] a);
    int i;
    for (i = 0; i < CELLS; i++) cells[i] = {a, CH_SP};
  endfunction

  function int cell_index(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return int'(r) * COLUMNS + int'(c);
  endfunction

  function void set_attr(logic [7:0] a);
    attr = a;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Rows move up one; the bottom row comes in blank in the current attribute.
  function void scroll_up();
    int i;
    for (i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
    for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_SP};
  endfunction

  // Put character; returns 1 when the screen scrolled.
  function bit put_character(logic [7:0] ch);
    bit did_scroll;
    bit done;
    int col_sum;
    int k;
    did_scroll = 1'b0;
    done = 1'b0;
    if (ch == CH_NUL) return 1'b0;
    if ((ch == CH_LF || ch == CH_CR) && cur_row != ROWS - 1) begin
      cur_row++;
      cur_col = '0;
    end else if (ch == CH_TAB) begin
      col_sum = int'(cur_col) + 4;
      if (col_sum >= COLUMNS) begin
        cur_col = COL_W'(col_sum % COLUMNS);
        if (cur_row == ROWS - 1) begin
          // wrap on the bottom row scrolls and keeps the wrapped column
          scroll_up();
          did_scroll = 1'b1;
          done = 1'b1;
        end else begin
          cur_row++;
        end
      end else begin
        cur_col = COL_W'(col_sum);
      end
    end else if (ch == CH_BS) begin
      if (cur_col == 0 && cur_row > 0) begin
        cur_col = COL_W'(COLUMNS - 2);
        cur_row--;
      end else if (cur_col != 0) begin
        cur_col--;
      end
      k = cell_index(cur_row, cur_col);
      cells[k][7:0] = CH_SP;
    end else if (ch == CH_LF && cur_row == ROWS - 1) begin
      scroll_up();
      cur_col = '0;
      did_scroll = 1'b1;
      done = 1'b1;
    end else if (cur_col == COLUMNS - 1 && cur_row != ROWS - 1) begin
      // last column above the bottom: move down, character dropped
      cur_row++;
      cur_col = '0;
    end else begin
      cells[cell_index(cur_row, cur_col)] = {attr, ch};
      cur_col = COL_W'((int'(cur_col) + 1) % COLUMNS);
      done = 1'b1;
    end
    if (!done && cur_row == ROWS - 1 && cur_col == COLUMNS - 1) begin
      scroll_up();
      cur_col = '0;
      did_scroll = 1'b1;
    end
    return did_scroll;
  endfunction

  // Accepted request: advance the model and queue the result it gives.
  function void note_request(in_req_t r);
    out_res_t         want;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] rw;
    logic [15:0]      v;
    want = '0;
    c  = (r.col > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : r.col;
    rw = (r.row > ROWS - 1) ? ROW_W'(ROWS - 1) : r.row;
    case (r.cmd)
      CMD_PUT: begin
        n_put++;
        want.scrolled = put_character(r.char_code);
        if (want.scrolled) n_scroll++;
      end
      CMD_CLEAR: begin
        n_clear++;
        fill_blank(attr);
        cur_col = '0;
        cur_row = '0;
      end
      CMD_SET: begin
        n_set++;
        cur_col = c;
        cur_row = rw;
      end
      CMD_READ: begin
        n_read++;
        v = cells[cell_index(rw, c)];
        want.cell_glyph = v[7:0];
        want.cell_attr  = v[15:8];
      end
    endcase
    want.cursor_col = cur_col;
    want.cursor_row = cur_row;
    want.cursor_pos = POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
    expected_q.push_back(want);
  endfunction

  function void check_result(out_res_t got);
    out_res_t want;
    bit       bad;
    checked++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with no request pending: col %0d row %0d pos %0d",
                 $realtime, got.cursor_col, got.cursor_row, got.cursor_pos);
      return;
    end
    want = expected_q.pop_front();
    bad = (got.cursor_col !== want.cursor_col) || (got.cursor_row !== want.cursor_row) ||
          (got.cursor_pos !== want.cursor_pos) || (got.cell_glyph !== want.cell_glyph) ||
          (got.cell_attr !== want.cell_attr) || (got.scrolled !== want.scrolled);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch on result %0d", $realtime, checked);
        $display("  exp col %0d row %0d pos %0d glyph %h attr %h scrolled %b",
                 want.cursor_col, want.cursor_row, want.cursor_pos,
                 want.cell_glyph, want.cell_attr, want.scrolled);
        $display("  got col %0d row %0d pos %0d glyph %h attr %h scrolled %b",
                 got.cursor_col, got.cursor_row, got.cursor_pos,
                 got.cell_glyph, got.cell_attr, got.scrolled);
      end
    end
  endfunction
endclass

module tb_text_console_cursor_scroll;

  localparam int RANDOM_PER_PHASE = 150;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_req_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_res_t  out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  console_scoreboard sb;

  // sender and receiver pacing state
  int calm_left;      // sender: requests left in a no-gap stretch
  int hold_left;      // receiver: cycles of stall still to apply
  int free_left;      // receiver: cycles of no stall still to apply
  int long_holds;     // receiver: long hold-offs done so far
  int attr_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_cursor_scroll dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic in_req_t mk_req(cmd_t c, logic [7:0] ch,
                                     logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    in_req_t r;
    r.cmd = c;
    r.char_code = ch;
    r.col = col;
    r.row = row;
    return r;
  endfunction

  // Random request. Puts dominate and lean on printable text and control codes;
  // cursor moves often aim at the bottom right so that wraps and scrolls happen.
  // Unused fields always carry random bits.
  function automatic in_req_t random_request();
    in_req_t r;
    int p;
    int q;
    r.cmd = CMD_PUT;
    r.char_code = 8'($urandom_range(255));
    r.col = COL_W'($urandom_range(127));
    r.row = ROW_W'($urandom_range(31));
    p = $urandom_range(99);
    q = $urandom_range(99);
    if (p < 64) begin
      if (q < 50)      r.char_code = 8'($urandom_range(8'h7E, 8'h21));
      else if (q < 58) r.char_code = CH_LF;
      else if (q < 63) r.char_code = CH_CR;
      else if (q < 70) r.char_code = CH_TAB;
      else if (q < 77) r.char_code = CH_BS;
      else if (q < 80) r.char_code = CH_NUL;
    end else if (p < 82) begin
      r.cmd = CMD_SET;
      if (q < 45) begin
        r.col = COL_W'($urandom_range(COLUMNS - 1));
        r.row = ROW_W'($urandom_range(ROWS - 1));
      end else if (q < 80) begin
        r.col = COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 10));
        r.row = ROW_W'($urandom_range(ROWS - 1, ROWS - 3));
      end
    end else if (p < 98) begin
      r.cmd = CMD_READ;
      if (q < 70) begin
        r.col = COL_W'($urandom_range(COLUMNS - 1));
        r.row = ROW_W'($urandom_range(ROWS - 1));
      end
    end else begin
      r.cmd = CMD_CLEAR;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input in_req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Gap after a request: mostly none or short, a few long, some calm stretches.
  task automatic sender_gap();
    int n;
    int p;
    n = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      p = $urandom_range(99);
      if (p < 50)      n = 0;
      else if (p < 85) n = $urandom_range(3, 1);
      else if (p < 96) n = $urandom_range(15, 4);
      else if (p < 98) n = $urandom_range(80, 20);
      else             calm_left = $urandom_range(60, 20);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Sender holds off until every expected result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_attr(value);
    attr_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_request(random_request());
      sender_gap();
    end
  endtask

  // Directed opening: field extremes, every command and every put-char corner.
  task automatic run_directed();
    in_req_t seq [$];
    int i;
    seq.push_back(mk_req(CMD_READ, 8'h00, 7'd0, 5'd0));     // store comes up blank
    seq.push_back(mk_req(CMD_PUT, 8'h41, 7'd0, 5'd0));
    seq.push_back(mk_req(CMD_PUT, 8'hFF, 7'd0, 5'd0));      // top glyph value
    seq.push_back(mk_req(CMD_PUT, CH_NUL, 7'd0, 5'd0));     // no effect
    seq.push_back(mk_req(CMD_PUT, CH_TAB, 7'd0, 5'd0));
    seq.push_back(mk_req(CMD_PUT, CH_BS, 7'd0, 5'd0));
    seq.push_back(mk_req(CMD_PUT, CH_CR, 7'd0, 5'd0));
    seq.push_back(mk_req(CMD_PUT, CH_LF, 7'd0, 5'd0));
    seq.push_back(mk_req(CMD_SET, 8'h00, 7'd127, 5'd31));   // clamps to bottom right
    seq.push_back(mk_req(CMD_PUT, 8'h80, 7'd0, 5'd0));      // write at last cell, wrap in row
    seq.push_back(mk_req(CMD_READ, 8'h00, 7'd127, 5'd31));  // clamped read sees it
    seq.push_back(mk_req(CMD_PUT, CH_CR, 7'd0, 5'd0));      // CR on bottom row is a glyph
    seq.push_back(mk_req(CMD_PUT, CH_LF, 7'd0, 5'd0));      // LF on bottom row scrolls
    seq.push_back(mk_req(CMD_SET, 8'h00, 7'd75, 5'd24));
    seq.push_back(mk_req(CMD_PUT, CH_TAB, 7'd0, 5'd0));     // tab lands on last cell
    seq.push_back(mk_req(CMD_SET, 8'h00, 7'd78, 5'd24));
    seq.push_back(mk_req(CMD_PUT, CH_TAB, 7'd0, 5'd0));     // tab wrap on bottom row
    seq.push_back(mk_req(CMD_SET, 8'h00, 7'd79, 5'd3));
    seq.push_back(mk_req(CMD_PUT, 8'h78, 7'd0, 5'd0));      // last column: dropped
    seq.push_back(mk_req(CMD_PUT, CH_BS, 7'd0, 5'd0));      // back to column 78 above
    seq.push_back(mk_req(CMD_CLEAR, 8'h00, 7'd0, 5'd0));
    seq.push_back(mk_req(CMD_PUT, CH_BS, 7'd0, 5'd0));      // top-left: cursor stays
    seq.push_back(mk_req(CMD_READ, 8'h00, 7'd0, 5'd0));
    seq.push_back(mk_req(CMD_SET, 8'h00, 7'd77, 5'd10));
    seq.push_back(mk_req(CMD_PUT, CH_TAB, 7'd0, 5'd0));     // tab wrap to next row
    for (i = 0; i < seq.size(); i++) begin
      send_request(seq[i]);
      sender_gap();
    end
  endtask

  // Receiver: checks at the rising edge, picks the next stall at the falling edge.
  // Twice in the run it holds off for a long stretch so the block backs up.
  initial begin : receiver
    int p;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_data);
      @(negedge clk);
      if (long_holds < 2 && hold_left == 0 &&
          sb.checked >= ((long_holds == 0) ? 80 : 300)) begin
        hold_left = 600;
        long_holds++;
      end
      if (hold_left == 0 && free_left == 0) begin
        p = $urandom_range(99);
        if (p < 55)      hold_left = 0;
        else if (p < 88) hold_left = $urandom_range(3, 1);
        else if (p < 97) hold_left = $urandom_range(20, 4);
        else if (p < 99) hold_left = $urandom_range(150, 40);
        else             free_left = $urandom_range(200, 50);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) free_left--;
      end
    end
  end

  // Main sequence: reset, directed part at the reset attribute, then random
  // phases under different attributes with a full drain before each write.
  initial begin : stimulus
    sb = new();
    calm_left = 0;
    hold_left = 0;
    free_left = 0;
    long_holds = 0;
    attr_writes = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    wait_drained();

    write_attribute(8'hFF);
    run_random(RANDOM_PER_PHASE);
    wait_drained();

    write_attribute(8'h00);
    send_request(mk_req(CMD_CLEAR, 8'h00, 7'd0, 5'd0));   // blank screen in attribute 0
    run_random(RANDOM_PER_PHASE);
    wait_drained();

    write_attribute(8'($urandom_range(254, 1)));
    run_random(RANDOM_PER_PHASE);
    wait_drained();

    repeat (20) @(negedge clk);
    $display("Covered %0d requests: %0d put, %0d set, %0d read, %0d clear",
             sb.n_put + sb.n_set + sb.n_read + sb.n_clear,
             sb.n_put, sb.n_set, sb.n_read, sb.n_clear);
    $display("with %0d scrolls, %0d attribute writes, %0d mismatches",
             sb.n_scroll, attr_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond a run where every request scrolls.
  initial begin : watchdog
    #50ms;
    $display("Timeout with %0d results pending", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tcc_pkg.sv
design/tcc_put_decode.sv
design/text_console_cursor_scroll.sv
dv/tb_text_console_cursor_scroll.sv
